// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring buffer check failed");

// Next-cycle implication, disabled while reset is high.
`define BRB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring buffer check failed");

`endif

// ===== rtl/brb_pkg.sv =====
// Shared types, constants and helper functions of the byte ring buffer.
// No dependencies; every other file of the block but assert_macros.svh uses it.
`default_nettype none

package brb_pkg;

  localparam int DEPTH = 256;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  localparam logic [2:0] OP_PUSH      = 3'd0;
  localparam logic [2:0] OP_POP       = 3'd1;
  localparam logic [2:0] OP_ADV_WRITE = 3'd2;
  localparam logic [2:0] OP_ADV_READ  = 3'd3;
  localparam logic [2:0] OP_STEP_BACK = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  // One result on its way from the control stage to the output register.
  typedef struct packed {
    logic [CNT_W-1:0] moved;
    logic             last;
    logic             is_pop;
    logic [CNT_W-1:0] level;
    logic [PTR_W-1:0] rpos;
    logic [PTR_W-1:0] wpos;
  } stage_t;

  // Request to the single-port ring memory.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [PTR_W-1:0] addr;
    logic [7:0]       wdata;
  } ram_req_t;

  function automatic logic [CNT_W-1:0] min_cnt(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Clamp the capacity register to 1..DEPTH.
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = CNT_W'(1);
    else if (c > DEPTH_C) r = DEPTH_C;
    return r;
  endfunction

  // Position plus a count, wrapped once at the ring end.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] pos,
                                                input logic [CNT_W-1:0] n,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] s;
    s = {2'b00, pos} + {1'b0, n};
    if (s >= {1'b0, cap}) s = s - {1'b0, cap};
    return s[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/brb_ifs.sv =====
// Handshake interfaces of the byte ring buffer: input items, results and
// the capacity write channel. Depends on brb_pkg for field widths.
`default_nettype none

interface brb_item_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              op;
  logic [7:0]              data_byte;
  logic [brb_pkg::CNT_W-1:0] amount;

  modport source (output valid, output op, output data_byte, output amount,
                  input ready);
  modport sink (input valid, input op, input data_byte, input amount,
                output ready);
endinterface

interface brb_result_if;
  logic                    valid;
  logic                    ready;
  logic [brb_pkg::CNT_W-1:0] moved;
  logic [7:0]              out_byte;
  logic                    last;
  logic [brb_pkg::CNT_W-1:0] level;
  logic [brb_pkg::CNT_W-1:0] read_run;
  logic [brb_pkg::CNT_W-1:0] write_run;

  modport source (output valid, output moved, output out_byte, output last,
                  output level, output read_run, output write_run,
                  input ready);
  modport sink (input valid, input moved, input out_byte, input last,
                input level, input read_run, input write_run,
                output ready);
endinterface

interface brb_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [brb_pkg::CNT_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ===== rtl/brb_ram.sv =====
// Single-port ring memory with a registered read port.
// Depends on brb_pkg for depth, address width and the request type.
`default_nettype none

module brb_ram (
  input  wire               clk,
  input  brb_pkg::ram_req_t req,
  output logic [7:0]        rdata
);
  import brb_pkg::*;

  logic [7:0] mem [DEPTH];

  // Read data holds whenever no read is issued, so an undelivered byte
  // can wait here until the output register is free.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brb_ctrl.sv =====
// Pointer, level and burst control of the byte ring buffer.
// Depends on brb_pkg and brb_ifs; drives the ring memory and the stage register.
`default_nettype none

module brb_ctrl #(
  parameter int MAX_BURST = 64
) (
  input  wire                        clk,
  input  wire                        rst,
  brb_item_if.sink                   items,
  brb_cfg_if.sink                    cfg,
  output brb_pkg::ram_req_t          ram_req,
  output logic                       s1_valid,
  output brb_pkg::stage_t            s1,
  input  wire                        s1_load,
  output logic [brb_pkg::CNT_W-1:0]  cap
);
  import brb_pkg::*;

  localparam int BW = $clog2(MAX_BURST + 1);
  localparam logic [CNT_W-1:0] BURST_C = CNT_W'(MAX_BURST);

  logic [PTR_W-1:0] wpos, wpos_next;
  logic [PTR_W-1:0] rpos, rpos_next;
  logic [CNT_W-1:0] level, level_next;
  logic [BW-1:0]    cnt, cnt_next;
  logic             s1_free, busy, accept, burst_issue;
  stage_t           s1_next;

  assign s1_free     = !s1_valid || s1_load;
  assign busy        = (cnt != '0);
  assign items.ready = !busy && s1_free;
  assign accept      = items.valid && items.ready;
  assign burst_issue = busy && s1_free;
  assign cfg.ready   = 1'b1;

  always_comb begin
    logic [CNT_W-1:0] n;
    n            = min_cnt(min_cnt(items.amount, level), BURST_C);
    wpos_next    = wpos;
    rpos_next    = rpos;
    level_next   = level;
    cnt_next     = cnt;
    ram_req.we   = 1'b0;
    ram_req.re   = 1'b0;
    ram_req.addr = rpos;
    ram_req.wdata = items.data_byte;
    s1_next.moved  = '0;
    s1_next.last   = 1'b1;
    s1_next.is_pop = 1'b0;

    if (burst_issue) begin
      ram_req.re     = 1'b1;
      rpos_next      = wrap_add(rpos, CNT_W'(1), cap);
      level_next     = level - CNT_W'(1);
      cnt_next       = cnt - BW'(1);
      s1_next.moved  = CNT_W'(1);
      s1_next.is_pop = 1'b1;
      s1_next.last   = (cnt == BW'(1));
    end else if (accept) begin
      unique case (items.op)
        OP_PUSH: begin
          if (level < cap) begin
            ram_req.we    = 1'b1;
            ram_req.addr  = wpos;
            wpos_next     = wrap_add(wpos, CNT_W'(1), cap);
            level_next    = level + CNT_W'(1);
            s1_next.moved = CNT_W'(1);
          end
        end
        OP_POP: begin
          if (n != '0) begin
            ram_req.re     = 1'b1;
            rpos_next      = wrap_add(rpos, CNT_W'(1), cap);
            level_next     = level - CNT_W'(1);
            cnt_next       = BW'(n - CNT_W'(1));
            s1_next.moved  = CNT_W'(1);
            s1_next.is_pop = 1'b1;
            s1_next.last   = (n == CNT_W'(1));
          end
        end
        OP_ADV_WRITE: begin
          s1_next.moved = min_cnt(items.amount, cap - level);
          wpos_next     = wrap_add(wpos, s1_next.moved, cap);
          level_next    = level + s1_next.moved;
        end
        OP_ADV_READ: begin
          s1_next.moved = min_cnt(items.amount, level);
          rpos_next     = wrap_add(rpos, s1_next.moved, cap);
          level_next    = level - s1_next.moved;
        end
        OP_STEP_BACK: begin
          if (level != '0) begin
            wpos_next     = (wpos == '0) ? PTR_W'(cap - CNT_W'(1)) : wpos - PTR_W'(1);
            level_next    = level - CNT_W'(1);
            s1_next.moved = CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          wpos_next  = '0;
          rpos_next  = '0;
          level_next = '0;
        end
        default: begin
        end
      endcase
    end

    s1_next.level = level_next;
    s1_next.rpos  = rpos_next;
    s1_next.wpos  = wpos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos     <= '0;
      rpos     <= '0;
      level    <= '0;
      cnt      <= '0;
      cap      <= DEPTH_C;
      s1_valid <= 1'b0;
    end else begin
      wpos  <= wpos_next;
      rpos  <= rpos_next;
      level <= level_next;
      cnt   <= cnt_next;
      if (accept || burst_issue) begin
        s1_valid <= 1'b1;
      end else if (s1_load) begin
        s1_valid <= 1'b0;
      end
      // A capacity write also empties the ring.
      if (cfg.valid && cfg.ready) begin
        cap   <= eff_cap(cfg.capacity);
        wpos  <= '0;
        rpos  <= '0;
        level <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept || burst_issue) begin
      s1 <= s1_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brb_out.sv =====
// Output register of the byte ring buffer: merges memory read data with the
// staged result and derives the contiguous runs. Depends on brb_pkg, brb_ifs.
`default_nettype none

module brb_out (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s1_valid,
  input  brb_pkg::stage_t            s1,
  input  wire  [7:0]                 rdata,
  input  wire  [brb_pkg::CNT_W-1:0]  cap,
  output logic                       s1_load,
  brb_result_if.source               results
);
  import brb_pkg::*;

  logic out_valid;

  assign results.valid = out_valid;
  assign s1_load = s1_valid && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      results.moved     <= s1.moved;
      results.out_byte  <= s1.is_pop ? rdata : 8'd0;
      results.last      <= s1.last;
      results.level     <= s1.level;
      results.read_run  <= min_cnt(cap - {1'b0, s1.rpos}, s1.level);
      results.write_run <= min_cnt(cap - {1'b0, s1.wpos}, cap - s1.level);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/byte_ring_buffer.sv =====
// Top level of the byte ring buffer: control, ring memory and output register.
// Depends on brb_pkg, brb_ifs, brb_ram, brb_ctrl and brb_out.
//
// Usage: items arrive on the items channel (op, data_byte, amount) and are
// taken when valid and ready are both high. Every item causes one result on
// the results channel, except a pop burst, which causes one result per byte
// delivered (at most MAX_BURST), the final one flagged by last. Each result
// reports the level and the contiguous readable and writable runs.
// A result passes through the staging register and then the output register.
// Throughput: one item per cycle for every operation other than a pop burst,
// while results are taken; a burst makes one memory read per byte through the
// single port of the ring memory, and no new item is taken until the last
// read of the burst has been issued.
// The cfg channel writes the capacity (clamped to 1..256); it also empties
// the ring and must only be used while the block is idle.
// Reset: positions, level and every valid flag clear, capacity returns to
// 256. The memory contents are not cleared, so no clearing pass is needed.
// Stall: the output register holds its result while results.ready is low;
// one further result may wait in the staging register and the memory read
// data, after which items.ready drops until the receiver takes a result.
`default_nettype none

module byte_ring_buffer #(
  parameter int MAX_BURST = 64
) (
  input  wire          clk,
  input  wire          rst,
  brb_item_if.sink     items,
  brb_result_if.source results,
  brb_cfg_if.sink      cfg
);
  import brb_pkg::*;

  ram_req_t         ram_req;
  logic [7:0]       rdata;
  logic             s1_valid;
  stage_t           s1;
  logic             s1_load;
  logic [CNT_W-1:0] cap;

  // Pointer arithmetic and burst sequencing.
  brb_ctrl #(
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .cfg      (cfg),
    .ram_req  (ram_req),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_load  (s1_load),
    .cap      (cap)
  );

  // Ring storage; a push writes and a pop reads, never in the same cycle.
  brb_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // Result register toward the receiver.
  brb_out u_out (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .rdata    (rdata),
    .cap      (cap),
    .s1_load  (s1_load),
    .results  (results)
  );

endmodule

`default_nettype wire

// ===== rtl/brb_check.sv =====
// Port-level checks of the byte ring buffer and their bind to the top level.
// Depends on brb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module brb_check (
  input wire                       clk,
  input wire                       rst,
  input wire                       res_valid,
  input wire                       res_ready,
  input wire [brb_pkg::CNT_W-1:0]  moved,
  input wire [7:0]                 out_byte,
  input wire                       last,
  input wire [brb_pkg::CNT_W-1:0]  level,
  input wire [brb_pkg::CNT_W-1:0]  read_run,
  input wire [brb_pkg::CNT_W-1:0]  write_run
);
  import brb_pkg::*;

  // Every field of the result, gathered so a stall can be checked at once.
  logic [4*CNT_W+8:0] res_word;

  assign res_word = {moved, out_byte, last, level, read_run, write_run};

  // A stalled result keeps its contents.
  `BRB_ASSERT_NXT(a_hold, res_valid && !res_ready, res_valid && $stable(res_word))

  // The readable run never exceeds what is stored.
  `BRB_ASSERT_IMP(a_read_run, res_valid, read_run <= level)

  // Stored bytes plus the writable run never exceed the ring size.
  `BRB_ASSERT_IMP(a_write_run, res_valid, ({1'b0, write_run} + {1'b0, level}) <= {1'b0, DEPTH_C})

  // Every result not flagged by last carries a count of one.
  `BRB_ASSERT_IMP(a_burst_moved, res_valid && !last, moved == CNT_W'(1))

endmodule

bind byte_ring_buffer brb_check u_brb_check (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .moved     (results.moved),
  .out_byte  (results.out_byte),
  .last      (results.last),
  .level     (results.level),
  .read_run  (results.read_run),
  .write_run (results.write_run)
);

`default_nettype wire
